// ----- hw/rtl/cpv_pkg.sv -----
// Shared widths and word types for the circle push-out vector pipeline.
`timescale 1ns / 1ps

package cpv_pkg;

	localparam int COORD_BITS = 24;
	localparam int RAD_BITS   = COORD_BITS - 1;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int C_BITS     = COORD_BITS + 2;
	localparam int MAG_BITS   = COORD_BITS + 1;
	localparam int SQ_BITS    = 2 * MAG_BITS + 1;
	localparam int ROOT_BITS  = MAG_BITS + 1;
	localparam int RADP_BITS  = 2 * ROOT_BITS;
	localparam int REM_S_BITS = ROOT_BITS + 2;
	localparam int RLEN_BITS  = COORD_BITS;
	localparam int QUO_BITS   = COORD_BITS;
	localparam int PROD_BITS  = MAG_BITS + RLEN_BITS;
	localparam int NUM_BITS   = PROD_BITS + 2;
	localparam int DEN_BITS   = ROOT_BITS + 1;
	localparam int PUSH_BITS  = C_BITS + 1;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] static_x;
		logic signed [COORD_BITS-1:0] static_y;
		logic [RAD_BITS-1:0] static_radius;
		logic signed [COORD_BITS-1:0] mover_x;
		logic signed [COORD_BITS-1:0] mover_y;
		logic [RAD_BITS-1:0] mover_radius;
		logic signed [COORD_BITS-1:0] move_dx;
		logic signed [COORD_BITS-1:0] move_dy;
	} in_word_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] push_x;
		logic signed [COORD_BITS-1:0] push_y;
		logic inward_mode;
		logic correction_needed;
		logic saturated;
	} out_word_t;

endpackage

// ----- hw/rtl/cpv_sqrt_cell.sv -----
// One cell of the square root chain: settles one root bit per cycle.
`timescale 1ns / 1ps

module cpv_sqrt_cell (
	input  logic clk,
	input  logic [cpv_pkg::REM_S_BITS-1:0] rem_i,
	input  logic [cpv_pkg::ROOT_BITS-1:0] root_i,
	input  logic [cpv_pkg::RADP_BITS-1:0] rad_i,
	output logic [cpv_pkg::REM_S_BITS-1:0] rem_o,
	output logic [cpv_pkg::ROOT_BITS-1:0] root_o,
	output logic [cpv_pkg::RADP_BITS-1:0] rad_o
);
	import cpv_pkg::*;

	logic [REM_S_BITS+1:0] rem_n;
	logic [REM_S_BITS+1:0] trial;
	logic ge;

	assign rem_n = {rem_i, rad_i[RADP_BITS-1 -: 2]};
	assign trial = (REM_S_BITS + 2)'({root_i, 2'b01});
	assign ge = rem_n >= trial;

	always_ff @(posedge clk) begin
		rem_o <= ge ? REM_S_BITS'(rem_n - trial) : REM_S_BITS'(rem_n);
		root_o <= {root_i[ROOT_BITS-2:0], ge};
		rad_o <= {rad_i[RADP_BITS-3:0], 2'b00};
	end

endmodule

// ----- hw/rtl/cpv_div_cell.sv -----
// One cell of a restoring divider chain: settles one quotient bit per cycle.
`timescale 1ns / 1ps

module cpv_div_cell (
	input  logic clk,
	input  logic [cpv_pkg::DEN_BITS-1:0] rem_i,
	input  logic [cpv_pkg::QUO_BITS-1:0] nlo_i,
	input  logic [cpv_pkg::QUO_BITS-1:0] quo_i,
	input  logic [cpv_pkg::DEN_BITS-1:0] den_i,
	output logic [cpv_pkg::DEN_BITS-1:0] rem_o,
	output logic [cpv_pkg::QUO_BITS-1:0] nlo_o,
	output logic [cpv_pkg::QUO_BITS-1:0] quo_o,
	output logic [cpv_pkg::DEN_BITS-1:0] den_o
);
	import cpv_pkg::*;

	logic [DEN_BITS:0] rem_n;
	logic [DEN_BITS:0] den_x;
	logic ge;

	assign rem_n = {rem_i, nlo_i[QUO_BITS-1]};
	assign den_x = {1'b0, den_i};
	assign ge = rem_n >= den_x;

	always_ff @(posedge clk) begin
		rem_o <= ge ? DEN_BITS'(rem_n - den_x) : DEN_BITS'(rem_n);
		nlo_o <= {nlo_i[QUO_BITS-2:0], 1'b0};
		quo_o <= {quo_i[QUO_BITS-2:0], ge};
		den_o <= den_i;
	end

endmodule

// ----- hw/rtl/circle_pushout_vector.sv -----
// Top level of the circle push-out vector pipeline.
// Words pass stages 1 to 6, the root chain, stage 7 and the divider chains to done.
// Throughput: one word per cycle; busy stays low, so start may be high in every cycle.
// The depth is set by the root chain (one cell per root bit) and the divider chains
// (one cell per quotient bit). The receiver cannot stall; done lasts one cycle.
// Reset clears all valid flags and done; words in flight at reset are dropped.
`timescale 1ns / 1ps

module circle_pushout_vector (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cpv_pkg::in_word_t in_word,
	output logic done,
	output cpv_pkg::out_word_t out_word
);
	import cpv_pkg::*;

	typedef struct packed {
		logic inward;
		logic need;
		logic nz;
		logic signed [C_BITS-1:0] cx;
		logic signed [C_BITS-1:0] cy;
		logic [PROD_BITS-1:0] px;
		logic [PROD_BITS-1:0] py;
	} side_t;

	localparam logic signed [PUSH_BITS-1:0] P_MAX = PUSH_BITS'(2 ** (COORD_BITS - 1) - 1);
	localparam logic signed [PUSH_BITS-1:0] P_MIN = ~P_MAX;
	localparam logic [COORD_BITS-1:0] OUT_MAX = P_MAX[COORD_BITS-1:0];
	localparam logic [COORD_BITS-1:0] OUT_MIN = P_MIN[COORD_BITS-1:0];

	assign busy = 1'b0;

	// Stage 1: offsets before and after the move.
	logic v_s1;
	logic signed [DIFF_BITS-1:0] dmx_s1, dmy_s1;
	logic signed [C_BITS-1:0] cx_s1, cy_s1;
	logic [RAD_BITS-1:0] r1_s1, r2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		dmx_s1 <= DIFF_BITS'(in_word.mover_x) - DIFF_BITS'(in_word.static_x);
		dmy_s1 <= DIFF_BITS'(in_word.mover_y) - DIFF_BITS'(in_word.static_y);
		cx_s1 <= C_BITS'(in_word.mover_x) + C_BITS'(in_word.move_dx) - C_BITS'(in_word.static_x);
		cy_s1 <= C_BITS'(in_word.mover_y) + C_BITS'(in_word.move_dy) - C_BITS'(in_word.static_y);
		r1_s1 <= in_word.static_radius;
		r2_s1 <= in_word.mover_radius;
	end

	// Stage 2: squares.
	logic [DIFF_BITS-1:0] dmx_mag, dmy_mag;
	logic [MAG_BITS-1:0] cx_mag, cy_mag;

	assign dmx_mag = dmx_s1[DIFF_BITS-1] ? DIFF_BITS'(-dmx_s1) : DIFF_BITS'(dmx_s1);
	assign dmy_mag = dmy_s1[DIFF_BITS-1] ? DIFF_BITS'(-dmy_s1) : DIFF_BITS'(dmy_s1);
	assign cx_mag = cx_s1[C_BITS-1] ? MAG_BITS'(-cx_s1) : MAG_BITS'(cx_s1);
	assign cy_mag = cy_s1[C_BITS-1] ? MAG_BITS'(-cy_s1) : MAG_BITS'(cy_s1);

	logic v_s2;
	logic [2*DIFF_BITS-1:0] dsx_s2, dsy_s2;
	logic [2*MAG_BITS-1:0] csx_s2, csy_s2;
	logic [2*RAD_BITS-1:0] r1sq_s2;
	logic [MAG_BITS-1:0] cxm_s2, cym_s2;
	logic [RAD_BITS-1:0] r1_s2, r2_s2;
	logic signed [C_BITS-1:0] cx_s2, cy_s2;

	always_ff @(posedge clk) begin
		dsx_s2 <= dmx_mag * dmx_mag;
		dsy_s2 <= dmy_mag * dmy_mag;
		csx_s2 <= cx_mag * cx_mag;
		csy_s2 <= cy_mag * cy_mag;
		r1sq_s2 <= r1_s1 * r1_s1;
		cxm_s2 <= cx_mag;
		cym_s2 <= cy_mag;
		r1_s2 <= r1_s1;
		r2_s2 <= r2_s1;
		cx_s2 <= cx_s1;
		cy_s2 <= cy_s1;
	end

	// Stage 3: sums of squares and both candidate lengths.
	logic v_s3;
	logic [2*DIFF_BITS:0] sd_s3;
	logic [SQ_BITS-1:0] s_s3;
	logic [2*RAD_BITS-1:0] r1sq_s3;
	logic r1gt_s3;
	logic [RLEN_BITS-1:0] rsum_s3, rdif_s3;
	logic [MAG_BITS-1:0] cxm_s3, cym_s3;
	logic signed [C_BITS-1:0] cx_s3, cy_s3;

	always_ff @(posedge clk) begin
		sd_s3 <= (2*DIFF_BITS+1)'(dsx_s2) + (2*DIFF_BITS+1)'(dsy_s2);
		s_s3 <= SQ_BITS'(csx_s2) + SQ_BITS'(csy_s2);
		r1sq_s3 <= r1sq_s2;
		r1gt_s3 <= r1_s2 > r2_s2;
		rsum_s3 <= RLEN_BITS'(r1_s2) + RLEN_BITS'(r2_s2);
		rdif_s3 <= RLEN_BITS'(r1_s2) - RLEN_BITS'(r2_s2);
		cxm_s3 <= cxm_s2;
		cym_s3 <= cym_s2;
		cx_s3 <= cx_s2;
		cy_s3 <= cy_s2;
	end

	// Stage 4: push direction and target length.
	logic v_s4;
	logic inward_s4;
	logic [RLEN_BITS-1:0] rlen_s4;
	logic [SQ_BITS-1:0] s_s4;
	logic [MAG_BITS-1:0] cxm_s4, cym_s4;
	logic signed [C_BITS-1:0] cx_s4, cy_s4;
	logic inward_c;

	assign inward_c = r1gt_s3 && (sd_s3 < (2*DIFF_BITS+1)'(r1sq_s3));

	always_ff @(posedge clk) begin
		inward_s4 <= inward_c;
		rlen_s4 <= inward_c ? rdif_s3 : rsum_s3;
		s_s4 <= s_s3;
		cxm_s4 <= cxm_s3;
		cym_s4 <= cym_s3;
		cx_s4 <= cx_s3;
		cy_s4 <= cy_s3;
	end

	// Stage 5: target length squared and scaled magnitudes.
	logic v_s5;
	logic inward_s5;
	logic [2*RLEN_BITS-1:0] rl2_s5;
	logic [PROD_BITS-1:0] px_s5, py_s5;
	logic [SQ_BITS-1:0] s_s5;
	logic signed [C_BITS-1:0] cx_s5, cy_s5;

	always_ff @(posedge clk) begin
		inward_s5 <= inward_s4;
		rl2_s5 <= rlen_s4 * rlen_s4;
		px_s5 <= cxm_s4 * rlen_s4;
		py_s5 <= cym_s4 * rlen_s4;
		s_s5 <= s_s4;
		cx_s5 <= cx_s4;
		cy_s5 <= cy_s4;
	end

	// Stage 6: overlap test.
	logic v_s6;
	side_t side_s6;
	logic [SQ_BITS-1:0] s_s6;

	always_ff @(posedge clk) begin
		side_s6.inward <= inward_s5;
		side_s6.need <= inward_s5 ? (SQ_BITS'(rl2_s5) < s_s5) : (s_s5 < SQ_BITS'(rl2_s5));
		side_s6.nz <= s_s5 != '0;
		side_s6.cx <= cx_s5;
		side_s6.cy <= cy_s5;
		side_s6.px <= px_s5;
		side_s6.py <= py_s5;
		s_s6 <= s_s5;
	end

	// Root chain.
	logic [REM_S_BITS-1:0] srem_w [ROOT_BITS+1];
	logic [ROOT_BITS-1:0] root_w [ROOT_BITS+1];
	logic [RADP_BITS-1:0] rad_w [ROOT_BITS+1];
	logic [ROOT_BITS-1:0] vsq_q;
	side_t sbsq_q [ROOT_BITS];

	assign srem_w[0] = '0;
	assign root_w[0] = '0;
	assign rad_w[0] = RADP_BITS'(s_s6);

	for (genvar i = 0; i < ROOT_BITS; i++) begin : g_sqrt
		cpv_sqrt_cell u_cell (
			.clk(clk),
			.rem_i(srem_w[i]),
			.root_i(root_w[i]),
			.rad_i(rad_w[i]),
			.rem_o(srem_w[i+1]),
			.root_o(root_w[i+1]),
			.rad_o(rad_w[i+1])
		);
	end

	always_ff @(posedge clk) begin
		sbsq_q[0] <= side_s6;
		for (int i = 1; i < ROOT_BITS; i++) begin
			sbsq_q[i] <= sbsq_q[i-1];
		end
	end

	// Stage 7: rounded numerators and the shared denominator.
	logic v_s7;
	side_t side_s7;
	logic [NUM_BITS-1:0] numx_s7, numy_s7;
	logic [DEN_BITS-1:0] den_s7;

	always_ff @(posedge clk) begin
		side_s7 <= sbsq_q[ROOT_BITS-1];
		numx_s7 <= (NUM_BITS'(sbsq_q[ROOT_BITS-1].px) << 1) + NUM_BITS'(root_w[ROOT_BITS]);
		numy_s7 <= (NUM_BITS'(sbsq_q[ROOT_BITS-1].py) << 1) + NUM_BITS'(root_w[ROOT_BITS]);
		den_s7 <= {root_w[ROOT_BITS], 1'b0};
	end

	// Divider chains, one per component.
	logic [DEN_BITS-1:0] xrem_w [QUO_BITS+1];
	logic [QUO_BITS-1:0] xnlo_w [QUO_BITS+1];
	logic [QUO_BITS-1:0] xquo_w [QUO_BITS+1];
	logic [DEN_BITS-1:0] xden_w [QUO_BITS+1];
	logic [DEN_BITS-1:0] yrem_w [QUO_BITS+1];
	logic [QUO_BITS-1:0] ynlo_w [QUO_BITS+1];
	logic [QUO_BITS-1:0] yquo_w [QUO_BITS+1];
	logic [DEN_BITS-1:0] yden_w [QUO_BITS+1];
	logic [QUO_BITS-1:0] vdv_q;
	side_t sbdv_q [QUO_BITS];

	assign xrem_w[0] = numx_s7[NUM_BITS-1:QUO_BITS];
	assign xnlo_w[0] = numx_s7[QUO_BITS-1:0];
	assign xquo_w[0] = '0;
	assign xden_w[0] = den_s7;
	assign yrem_w[0] = numy_s7[NUM_BITS-1:QUO_BITS];
	assign ynlo_w[0] = numy_s7[QUO_BITS-1:0];
	assign yquo_w[0] = '0;
	assign yden_w[0] = den_s7;

	for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
		cpv_div_cell u_xcell (
			.clk(clk),
			.rem_i(xrem_w[i]),
			.nlo_i(xnlo_w[i]),
			.quo_i(xquo_w[i]),
			.den_i(xden_w[i]),
			.rem_o(xrem_w[i+1]),
			.nlo_o(xnlo_w[i+1]),
			.quo_o(xquo_w[i+1]),
			.den_o(xden_w[i+1])
		);
		cpv_div_cell u_ycell (
			.clk(clk),
			.rem_i(yrem_w[i]),
			.nlo_i(ynlo_w[i]),
			.quo_i(yquo_w[i]),
			.den_i(yden_w[i]),
			.rem_o(yrem_w[i+1]),
			.nlo_o(ynlo_w[i+1]),
			.quo_o(yquo_w[i+1]),
			.den_o(yden_w[i+1])
		);
	end

	always_ff @(posedge clk) begin
		sbdv_q[0] <= side_s7;
		for (int i = 1; i < QUO_BITS; i++) begin
			sbdv_q[i] <= sbdv_q[i-1];
		end
	end

	// Valid flags along the whole pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			vsq_q <= '0;
			v_s7 <= 1'b0;
			vdv_q <= '0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			vsq_q <= {vsq_q[ROOT_BITS-2:0], v_s6};
			v_s7 <= vsq_q[ROOT_BITS-1];
			vdv_q <= {vdv_q[QUO_BITS-2:0], v_s7};
		end
	end

	// Final stage: signed correction, clamp, output register.
	side_t side_f;
	logic signed [PUSH_BITS-1:0] qxs, qys, rawx, rawy;
	logic satx, saty, act;
	logic [COORD_BITS-1:0] clx, cly;

	assign side_f = sbdv_q[QUO_BITS-1];
	assign qxs = signed'(PUSH_BITS'(xquo_w[QUO_BITS]));
	assign qys = signed'(PUSH_BITS'(yquo_w[QUO_BITS]));
	assign rawx = (side_f.cx[C_BITS-1] ? -qxs : qxs) - PUSH_BITS'(side_f.cx);
	assign rawy = (side_f.cy[C_BITS-1] ? -qys : qys) - PUSH_BITS'(side_f.cy);
	assign satx = (rawx > P_MAX) || (rawx < P_MIN);
	assign saty = (rawy > P_MAX) || (rawy < P_MIN);
	assign clx = (rawx > P_MAX) ? OUT_MAX : (rawx < P_MIN) ? OUT_MIN : rawx[COORD_BITS-1:0];
	assign cly = (rawy > P_MAX) ? OUT_MAX : (rawy < P_MIN) ? OUT_MIN : rawy[COORD_BITS-1:0];
	assign act = side_f.need && side_f.nz;

	logic done_q;
	out_word_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vdv_q[QUO_BITS-1];
		end
	end

	always_ff @(posedge clk) begin
		out_q.push_x <= act ? clx : '0;
		out_q.push_y <= act ? cly : '0;
		out_q.inward_mode <= side_f.inward;
		out_q.correction_needed <= side_f.need;
		out_q.saturated <= act && (satx || saty);
	end

	assign done = done_q;
	assign out_word = out_q;

	a_zero_without_need: assert property (@(posedge clk) disable iff (!arst_n)
		done && !out_word.correction_needed |-> out_word.push_x == '0 && out_word.push_y == '0)
		else $error("push word is nonzero although no correction was needed");

	a_sat_needs_correction: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_word.saturated |-> out_word.correction_needed)
		else $error("saturation flagged on a word without correction");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_word.saturated |-> out_word.push_x == OUT_MAX || out_word.push_x == OUT_MIN
			|| out_word.push_y == OUT_MAX || out_word.push_y == OUT_MIN)
		else $error("saturation flagged but no component sits at a limit");

	a_done_follows_chain: assert property (@(posedge clk) disable iff (!arst_n)
		vdv_q[QUO_BITS-1] |=> done)
		else $error("word left the divider chain but done did not follow");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the circle push-out vector pipeline.
`timescale 1ns / 1ps

module tb;
	import cpv_pkg::*;

	localparam int N_RANDOM = 1430;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 80;
	localparam int PAUSE_AT = 500;
	localparam int IN_W = $bits(in_word_t);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	in_word_t in_word = '0;
	out_word_t out_word;

	in_word_t feed_q[$];
	out_word_t push_q[$];
	int n_acc = 0;
	int n_bad = 0;
	int stall_cnt = 0;
	bit paused_done = 1'b0;

	circle_pushout_vector dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.in_word(in_word),
		.done(done),
		.out_word(out_word)
	);

	always #6 clk = ~clk;

	// The radicand stays below 2^51, so the root fits in 32 bits and t * t never overflows.
	function automatic longint unsigned isqrt(longint unsigned s);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (!(s < t * t))
				r = t;
		end
		return r;
	endfunction

	function automatic longint push_comp(longint c, longint unsigned rlen, longint unsigned len);
		longint unsigned m;
		longint unsigned q;
		m = (c < 0) ? longint'(-c) : longint'(c);
		q = (m * (rlen << 1) + len) / (len << 1);
		return ((c < 0) ? -longint'(q) : longint'(q)) - c;
	endfunction

	function automatic longint clamp_coord(longint v, ref bit sat);
		longint hi;
		hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
		if (v > hi) begin
			sat = 1'b1;
			return hi;
		end
		if (v < -hi - 1) begin
			sat = 1'b1;
			return -hi - 1;
		end
		return v;
	endfunction

	function automatic out_word_t predict_push(in_word_t w);
		out_word_t o;
		longint sx, sy, mx, my, cx, cy, ox, oy, px, py;
		longint unsigned r1, r2, d0, s, rlen, len;
		bit inward, need, sat;
		sx = w.static_x;
		sy = w.static_y;
		mx = w.mover_x;
		my = w.mover_y;
		r1 = w.static_radius;
		r2 = w.mover_radius;
		ox = mx - sx;
		oy = my - sy;
		d0 = ox * ox + oy * oy;
		inward = (r1 > r2) && (d0 < r1 * r1);
		cx = mx + longint'(w.move_dx) - sx;
		cy = my + longint'(w.move_dy) - sy;
		s = cx * cx + cy * cy;
		rlen = inward ? r1 - r2 : r1 + r2;
		need = inward ? (rlen * rlen < s) : (s < rlen * rlen);
		sat = 1'b0;
		px = 0;
		py = 0;
		if (need && s != 0) begin
			len = isqrt(s);
			px = clamp_coord(push_comp(cx, rlen, len), sat);
			py = clamp_coord(push_comp(cy, rlen, len), sat);
		end
		o.push_x = px[COORD_BITS-1:0];
		o.push_y = py[COORD_BITS-1:0];
		o.inward_mode = inward;
		o.correction_needed = need;
		o.saturated = sat;
		return o;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] rnd_coord(int span);
		return COORD_BITS'($signed($urandom_range(2 * span)) - span);
	endfunction

	function automatic in_word_t make_pair();
		in_word_t w;
		int kind;
		int ra, rb, off;
		kind = $urandom_range(9);
		w = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		case (kind) inside
			[2:4]: begin
				ra = $urandom_range(1 << 16);
				rb = $urandom_range(1 << 16);
				off = (ra + rb) / 2 + 1;
				w.static_x = rnd_coord(1 << 20);
				w.static_y = rnd_coord(1 << 20);
				w.static_radius = RAD_BITS'(ra);
				w.mover_radius = RAD_BITS'(rb);
				w.mover_x = w.static_x + rnd_coord(off);
				w.mover_y = w.static_y + rnd_coord(off);
				w.move_dx = rnd_coord(off);
				w.move_dy = rnd_coord(off);
			end
			[5:7]: begin
				ra = $urandom_range(1 << 20, 16);
				rb = $urandom_range(ra - 1);
				w.static_x = rnd_coord(1 << 20);
				w.static_y = rnd_coord(1 << 20);
				w.static_radius = RAD_BITS'(ra);
				w.mover_radius = RAD_BITS'(rb);
				w.mover_x = w.static_x + rnd_coord(ra / 2);
				w.mover_y = w.static_y + rnd_coord(ra / 2);
				w.move_dx = rnd_coord(ra);
				w.move_dy = rnd_coord(ra);
			end
			8: begin
				w.static_x = rnd_coord(1 << 21);
				w.static_y = rnd_coord(1 << 21);
				w.mover_x = rnd_coord(1 << 21);
				w.mover_y = rnd_coord(1 << 21);
				w.move_dx = w.static_x - w.mover_x;
				w.move_dy = w.static_y - w.mover_y;
			end
			9: begin
				w.static_radius = RAD_BITS'($urandom_range(8388607, 8000000));
				w.mover_radius = RAD_BITS'($urandom_range(8388607, 7000000));
			end
			default: ;
		endcase
		return w;
	endfunction

	function automatic in_word_t pack_item(int sx, int sy, int ra, int mx, int my, int rb,
		int dx, int dy);
		in_word_t w;
		w.static_x = COORD_BITS'(sx);
		w.static_y = COORD_BITS'(sy);
		w.static_radius = RAD_BITS'(ra);
		w.mover_x = COORD_BITS'(mx);
		w.mover_y = COORD_BITS'(my);
		w.mover_radius = RAD_BITS'(rb);
		w.move_dx = COORD_BITS'(dx);
		w.move_dy = COORD_BITS'(dy);
		return w;
	endfunction

	initial begin
		localparam int MX = 8388607;
		localparam int MN = -8388608;
		feed_q.push_back(pack_item(0, 0, 0, 0, 0, 0, 0, 0));
		feed_q.push_back(pack_item(MX, MX, MX, MX, MX, MX, MX, MX));
		feed_q.push_back(pack_item(MN, MN, 0, MN, MN, 0, MN, MN));
		feed_q.push_back(pack_item(MN, MN, MX, MX, MX, MX, MX, MX));
		feed_q.push_back(pack_item(MX, MN, MX, MN, MX, MX, MN, MX));
		feed_q.push_back(pack_item(0, 0, 1000, 0, 0, 1000, 100, 0));
		feed_q.push_back(pack_item(0, 0, 5000, 100, 0, 1000, 0, 0));
		feed_q.push_back(pack_item(0, 0, 5000, 100, 0, 1000, 4000, 3000));
		feed_q.push_back(pack_item(0, 0, 5000, 100, 0, 1000, -100, 0));
		feed_q.push_back(pack_item(0, 0, 5000, 5000, 0, 1000, 0, 0));
		feed_q.push_back(pack_item(256, -256, 512, 0, 0, 256, 256, -256));
		feed_q.push_back(pack_item(0, 0, 300, 200, 0, 100, 0, 0));
		feed_q.push_back(pack_item(0, 0, 300, 1, 1, 200, 0, 0));
		feed_q.push_back(pack_item(MN, 0, MX, MX, 0, MX, 0, 0));
		feed_q.push_back(pack_item(0, 0, MX, 1, 0, 0, 0, 0));
		feed_q.push_back(pack_item(0, 0, MX, 1, 0, 0, MX, MX));
		feed_q.push_back(pack_item(10, 10, 7, 13, 14, 3, 0, 0));
		for (int i = 0; i < N_RANDOM; i++)
			feed_q.push_back(make_pair());
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (feed_q.size() != 0 || push_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_bad == 0 && push_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	always @(negedge clk) begin
		int idle_pct;
		idle_pct = (n_acc < 480) ? 10 : (n_acc < 960) ? 63 : 0;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (n_acc >= PAUSE_AT && !paused_done) begin
			start <= 1'b0;
			if (push_q.size() == 0)
				paused_done = 1'b1;
		end else if (feed_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
			start <= 1'b1;
			in_word <= feed_q[0];
		end else begin
			start <= 1'b0;
		end
	end

	always @(posedge clk) begin
		out_word_t want;
		bit moved;
		moved = 1'b0;
		if (arst_n && start && !busy) begin
			push_q.push_back(predict_push(in_word));
			void'(feed_q.pop_front());
			n_acc++;
			moved = 1'b1;
		end
		if (arst_n && done) begin
			moved = 1'b1;
			if (push_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("Unexpected result word %p", out_word);
			end else begin
				want = push_q.pop_front();
				if (out_word !== want) begin
					n_bad++;
					if (n_bad <= 10)
						$display("Mismatch: expected %p, got %p", want, out_word);
				end
			end
		end
		if (moved || !arst_n)
			stall_cnt = 0;
		else
			stall_cnt++;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

endmodule
